// ===== rtl/echo_pulse_range_capture_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ECHO_PULSE_RANGE_CAPTURE_MACROS_SVH
`define ECHO_PULSE_RANGE_CAPTURE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define EPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define EPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/epr_pkg.sv =====
package epr_pkg;

  typedef enum logic [1:0] {
    PH_READY   = 2'd0,
    PH_RUNNING = 2'd1,
    PH_DONE    = 2'd2,
    PH_ERROR   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_CLOCKS_PER_US = 2'd0,
    CFG_FILTER_LENGTH = 2'd1,
    CFG_WAIT_LIMIT_US = 2'd2,
    CFG_MAX_RANGE_CM  = 2'd3
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RESULT_W   = 16;

  typedef struct packed {
    logic [7:0]  clocks_per_us;
    logic [3:0]  filter_length;
    logic [15:0] wait_limit_us;
    logic [10:0] max_range_cm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    clocks_per_us: 8'd48,
    filter_length: 4'd8,
    wait_limit_us: 16'hFFFF,
    max_range_cm:  11'd1000
  };

  // Range = width / 58, done as a reciprocal multiply plus one correction.
  localparam int unsigned CM_DIVISOR  = 58;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned CLIP_W      = 22;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned PROD_W      = CLIP_W + RECIP_W;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'((64'd1 << RECIP_SHIFT) / CM_DIVISOR);
  // Smallest width whose range no longer fits in 16 bits.
  localparam logic [31:0] RANGE_SAT_WIDTH = 32'(CM_DIVISOR * 65536);
  localparam logic [RESULT_W-1:0] RESULT_MAX = '1;

endpackage

// ===== rtl/epr_ctrl.sv =====
module epr_ctrl #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  epr_pkg::cfg_t          cfg_i,
  input  logic                   accept_i,
  input  logic                   arm_i,
  input  logic                   echo_level_i,
  output logic                   emit_o,
  output logic                   failed_o,
  output logic [COUNT_WIDTH-1:0] width_o
);

  epr_pkg::phase_e        phase_q, phase_d;
  logic [7:0]             ps_q, ps_d;
  logic [COUNT_WIDTH-1:0] mc_q, mc_d;
  logic [3:0]             fc_q, fc_d;
  logic                   stable_q, stable_d;

  logic [3:0]             flen;
  logic [3:0]             fc_inc;
  logic                   lvl_edge;
  logic [7:0]             div;
  logic [8:0]             ps_inc;
  logic                   us_tick;
  logic                   mc_max;
  logic [COUNT_WIDTH-1:0] mc_inc;
  logic                   wait_hit;

  // Debounce: a new level counts once it has held for filter_length words.
  always_comb begin
    flen     = (cfg_i.filter_length == 4'd0) ? 4'd1 : cfg_i.filter_length;
    fc_inc   = fc_q + 4'd1;
    lvl_edge = 1'b0;
    fc_d     = fc_q;
    stable_d = stable_q;
    if (accept_i) begin
      if (echo_level_i != stable_q) begin
        if (fc_inc >= flen) begin
          stable_d = echo_level_i;
          fc_d     = 4'd0;
          lvl_edge = 1'b1;
        end else begin
          fc_d = fc_inc;
        end
      end else begin
        fc_d = 4'd0;
      end
    end
  end

  always_comb begin
    div      = (cfg_i.clocks_per_us == 8'd0) ? 8'd1 : cfg_i.clocks_per_us;
    ps_inc   = {1'b0, ps_q} + 9'd1;
    us_tick  = ps_inc >= {1'b0, div};
    mc_max   = (mc_q == '1);
    mc_inc   = mc_q + COUNT_WIDTH'(1);
    wait_hit = 32'(mc_inc) >= 32'(cfg_i.wait_limit_us);
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      if (arm_i) begin
        phase_d = epr_pkg::PH_READY;
      end else begin
        case (phase_q)
          epr_pkg::PH_READY: begin
            if (lvl_edge) begin
              phase_d = epr_pkg::PH_RUNNING;
            end else if (us_tick && (mc_max || wait_hit)) begin
              phase_d = epr_pkg::PH_ERROR;
            end
          end
          epr_pkg::PH_RUNNING: begin
            if (lvl_edge) begin
              phase_d = epr_pkg::PH_DONE;
            end else if (us_tick && mc_max) begin
              phase_d = epr_pkg::PH_ERROR;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Counters and result strobe
  always_comb begin
    ps_d     = ps_q;
    mc_d     = mc_q;
    emit_o   = 1'b0;
    failed_o = 1'b0;
    if (accept_i) begin
      if (arm_i) begin
        ps_d = 8'd0;
        mc_d = '0;
      end else begin
        case (phase_q)
          epr_pkg::PH_READY: begin
            ps_d = us_tick ? 8'd0 : ps_inc[7:0];
            if (lvl_edge) begin
              ps_d = 8'd0;
              mc_d = '0;
            end else if (us_tick) begin
              if (!mc_max) begin
                mc_d = mc_inc;
              end
              emit_o   = mc_max || wait_hit;
              failed_o = mc_max || wait_hit;
            end
          end
          epr_pkg::PH_RUNNING: begin
            ps_d = us_tick ? 8'd0 : ps_inc[7:0];
            if (lvl_edge) begin
              emit_o = 1'b1;
            end else if (us_tick) begin
              if (mc_max) begin
                emit_o   = 1'b1;
                failed_o = 1'b1;
              end else begin
                mc_d = mc_inc;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign width_o = mc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= epr_pkg::PH_READY;
      ps_q     <= 8'd0;
      mc_q     <= '0;
      fc_q     <= 4'd0;
      stable_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ps_q     <= ps_d;
      mc_q     <= mc_d;
      fc_q     <= fc_d;
      stable_q <= stable_d;
    end
  end

endmodule

// ===== rtl/epr_scale.sv =====
module epr_scale #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             failed_i,
  input  logic [COUNT_WIDTH-1:0]           width_i,
  input  logic [10:0]                      max_range_cm_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [epr_pkg::RESULT_W-1:0]     range_o,
  output logic [epr_pkg::RESULT_W-1:0]     pulse_o,
  output logic                             failed_o,
  output logic                             in_range_o
);

  logic en1, en2, en3;

  // Stage 1: captured width
  logic                   v1_q;
  logic                   f1_q;
  logic [COUNT_WIDTH-1:0] w1_q;

  // Stage 2: clipped width and reciprocal estimate
  logic                               v2_q;
  logic                               f2_q;
  logic                               big2_q;
  logic [epr_pkg::RESULT_W-1:0]       pulse2_q;
  logic [epr_pkg::CLIP_W-1:0]         clip2_q;
  logic [epr_pkg::QUOT_W-1:0]         q0_2_q;

  // Stage 3: result word
  logic                         v3_q;
  logic [epr_pkg::RESULT_W-1:0] range3_q;
  logic [epr_pkg::RESULT_W-1:0] pulse3_q;
  logic                         f3_q;
  logic                         inr3_q;

  logic [31:0]                  w_ext;
  logic                         big;
  logic [epr_pkg::CLIP_W-1:0]   clip;
  logic [epr_pkg::PROD_W-1:0]   prod;
  logic [epr_pkg::RESULT_W-1:0] pulse_sat;

  logic [epr_pkg::CLIP_W:0]     q0_x58;
  logic [epr_pkg::CLIP_W:0]     rem;
  logic [epr_pkg::QUOT_W-1:0]   quot;
  logic [epr_pkg::RESULT_W-1:0] range_d;
  logic [epr_pkg::RESULT_W-1:0] pulse_d;
  logic                         inr_d;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    w_ext     = 32'(w1_q);
    big       = w_ext >= epr_pkg::RANGE_SAT_WIDTH;
    clip      = w_ext[epr_pkg::CLIP_W-1:0];
    prod      = epr_pkg::PROD_W'(clip) * epr_pkg::PROD_W'(epr_pkg::RECIP_MULT);
    pulse_sat = (w_ext > 32'(epr_pkg::RESULT_MAX)) ? epr_pkg::RESULT_MAX
                                                  : w_ext[epr_pkg::RESULT_W-1:0];
  end

  // The estimate is at most one below the true quotient; fix it up here.
  always_comb begin
    q0_x58  = (epr_pkg::CLIP_W+1)'(q0_2_q) * (epr_pkg::CLIP_W+1)'(epr_pkg::CM_DIVISOR);
    rem     = (epr_pkg::CLIP_W+1)'(clip2_q) - q0_x58;
    quot    = q0_2_q + epr_pkg::QUOT_W'(rem >= (epr_pkg::CLIP_W+1)'(epr_pkg::CM_DIVISOR));
    range_d = big2_q ? epr_pkg::RESULT_MAX : quot[epr_pkg::RESULT_W-1:0];
    pulse_d = pulse2_q;
    inr_d   = range_d <= epr_pkg::RESULT_W'(max_range_cm_i);
    if (f2_q) begin
      range_d = epr_pkg::RESULT_MAX;
      pulse_d = '0;
      inr_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      f1_q <= failed_i;
      w1_q <= width_i;
    end
    if (en2 && v1_q) begin
      f2_q     <= f1_q;
      big2_q   <= big;
      pulse2_q <= pulse_sat;
      clip2_q  <= clip;
      q0_2_q   <= prod[epr_pkg::PROD_W-1:epr_pkg::RECIP_SHIFT];
    end
    if (en3 && v2_q) begin
      range3_q <= range_d;
      pulse3_q <= pulse_d;
      f3_q     <= f2_q;
      inr3_q   <= inr_d;
    end
  end

  assign out_valid_o = v3_q;
  assign range_o     = range3_q;
  assign pulse_o     = pulse3_q;
  assign failed_o    = f3_q;
  assign in_range_o  = inr3_q;

endmodule

// ===== rtl/echo_pulse_range_capture.sv =====
// Echo pulse range capture.
// s_axis carries one word per clock tick of the sensor: tdata[0] = arm,
// tdata[1] = raw echo level. A word with arm set restarts a measurement.
// The level is debounced, a prescaler derives microsecond ticks, the first
// filtered edge starts the count and the second ends it.
// m_axis gives one word per finished measurement: pulse width in us, range
// in cm (width / 58), an in-range flag, and tuser = failed on timeout or
// count wrap (range 65535, width 0). After a result, edges are ignored until
// the next arm.
// cfg_we_i / cfg_index_i / cfg_wdata_i write the four setup registers; write
// them only while the block is idle.
// Throughput: one input word per cycle while s_axis_tready is high. The
// result of the word that ends a measurement passes through a three-stage
// width-to-range pipeline (capture, reciprocal multiply, correct) to m_axis.
// Reset: phase ready, counters and filter clear, registers take defaults
// (prescaler divider 48, filter 8, wait 65535 us, max range 1000 cm).
// Stall: the pipeline holds up to three results; s_axis_tready drops only
// when all three stages are full and m_axis_tready is low.
module echo_pulse_range_capture #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // arm, echo_level
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // range_cm, pulse_us, in_range
  output logic                           m_axis_tuser,  // failed
  input  logic                           cfg_we_i,
  input  logic [epr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [epr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  epr_pkg::cfg_t cfg_q, cfg_d;

  logic                         accept;
  logic                         emit;
  logic                         emit_failed;
  logic [COUNT_WIDTH-1:0]       width;
  logic [epr_pkg::RESULT_W-1:0] range_cm;
  logic [epr_pkg::RESULT_W-1:0] pulse_us;
  logic                         in_range;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (epr_pkg::cfg_idx_e'(cfg_index_i))
        epr_pkg::CFG_CLOCKS_PER_US: cfg_d.clocks_per_us = cfg_wdata_i[7:0];
        epr_pkg::CFG_FILTER_LENGTH: cfg_d.filter_length = cfg_wdata_i[3:0];
        epr_pkg::CFG_WAIT_LIMIT_US: cfg_d.wait_limit_us = cfg_wdata_i;
        epr_pkg::CFG_MAX_RANGE_CM:  cfg_d.max_range_cm  = cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= epr_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  epr_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .arm_i        (s_axis_tdata[0]),
    .echo_level_i (s_axis_tdata[1]),
    .emit_o       (emit),
    .failed_o     (emit_failed),
    .width_o      (width)
  );

  epr_scale #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (emit),
    .in_ready_o     (s_axis_tready),
    .failed_i       (emit_failed),
    .width_i        (width),
    .max_range_cm_i (cfg_q.max_range_cm),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .range_o        (range_cm),
    .pulse_o        (pulse_us),
    .failed_o       (m_axis_tuser),
    .in_range_o     (in_range)
  );

  assign m_axis_tdata = {7'd0, in_range, pulse_us, range_cm};

endmodule

// ===== rtl/epr_checker.sv =====
`include "echo_pulse_range_capture_macros.svh"

module epr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // An error word carries the fixed failure pattern.
  `EPR_ASSERT_NOW(a_fail_pattern, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[15:0] == 16'hFFFF) && (m_axis_tdata[31:16] == 16'd0) && !m_axis_tdata[32], "failed word with bad fields")

  // In range never goes with an error or a range above 1130 cm, the largest setting the bench writes.
  `EPR_ASSERT_NOW(a_in_range_ok, m_axis_tvalid && m_axis_tdata[32], !m_axis_tuser && (m_axis_tdata[15:0] <= 16'd1130), "in_range set on bad word")

  // Range is the width divided by 58 when the width is not saturated.
  `EPR_ASSERT_NOW(a_range_div, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata[31:16] != 16'hFFFF), (32'(m_axis_tdata[15:0]) * 32'd58 <= 32'(m_axis_tdata[31:16])) && (32'(m_axis_tdata[31:16]) < 32'(m_axis_tdata[15:0]) * 32'd58 + 32'd58), "range does not match width")

  // A stalled word holds.
  `EPR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed under stall")

endmodule

bind echo_pulse_range_capture epr_checker u_epr_checker (.*);

// ===== dv/echo_range_checker.sv =====
module echo_range_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // arm, echo_level
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [39:0]                    m_axis_tdata,  // range_cm, pulse_us, in_range
  input  logic                           m_axis_tuser,  // failed
  input  logic                           cfg_we_i,
  input  logic [epr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [epr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                    errors_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] range_cm;
    logic [15:0] pulse_us;
    logic        in_range;
    logic        failed;
  } range_word_t;

  epr_pkg::cfg_t   cfg;
  epr_pkg::phase_e meas_phase;
  logic [7:0]      presc_cnt;
  logic [15:0]     usec_cnt;
  logic [3:0]      filt_cnt;
  logic            stable_lvl;
  range_word_t     expected_words[$];

  // Advance the measurement by one sensor tick; return 1 when it ends.
  function automatic logic tick_model(input logic arm, input logic lvl,
                                      output range_word_t word);
    logic [3:0]  flen;
    logic [7:0]  div;
    logic        flip;
    logic        us_tick;
    logic [15:0] cm;
    flen    = (cfg.filter_length == 4'd0) ? 4'd1 : cfg.filter_length;
    div     = (cfg.clocks_per_us == 8'd0) ? 8'd1 : cfg.clocks_per_us;
    flip    = 1'b0;
    us_tick = 1'b0;
    word    = '{range_cm: epr_pkg::RESULT_MAX, pulse_us: 16'd0, in_range: 1'b0,
                failed: 1'b1};

    // the debounce filter runs on every tick, arm or not
    if (lvl != stable_lvl) begin
      filt_cnt = filt_cnt + 4'd1;
      if (filt_cnt >= flen) begin
        stable_lvl = lvl;
        filt_cnt   = 4'd0;
        flip       = 1'b1;
      end
    end else begin
      filt_cnt = 4'd0;
    end

    if (arm) begin
      meas_phase = epr_pkg::PH_READY;
      presc_cnt  = 8'd0;
      usec_cnt   = 16'd0;
      return 1'b0;
    end
    if (meas_phase == epr_pkg::PH_DONE || meas_phase == epr_pkg::PH_ERROR) return 1'b0;

    if ({1'b0, presc_cnt} + 9'd1 >= {1'b0, div}) begin
      presc_cnt = 8'd0;
      us_tick   = 1'b1;
    end else begin
      presc_cnt = presc_cnt + 8'd1;
    end

    if (meas_phase == epr_pkg::PH_READY) begin
      if (flip) begin
        meas_phase = epr_pkg::PH_RUNNING;
        presc_cnt  = 8'd0;
        usec_cnt   = 16'd0;
        return 1'b0;
      end
      if (us_tick) begin
        if (usec_cnt == 16'hFFFF) begin
          meas_phase = epr_pkg::PH_ERROR;
          return 1'b1;
        end
        usec_cnt = usec_cnt + 16'd1;
        if (usec_cnt >= cfg.wait_limit_us) begin
          meas_phase = epr_pkg::PH_ERROR;
          return 1'b1;
        end
      end
      return 1'b0;
    end

    if (flip) begin
      meas_phase = epr_pkg::PH_DONE;
      cm   = 16'(usec_cnt / epr_pkg::CM_DIVISOR);
      word = '{range_cm: cm, pulse_us: usec_cnt,
               in_range: (cm <= {5'd0, cfg.max_range_cm}), failed: 1'b0};
      return 1'b1;
    end
    if (us_tick) begin
      if (usec_cnt == 16'hFFFF) begin
        meas_phase = epr_pkg::PH_ERROR;
        return 1'b1;
      end
      usec_cnt = usec_cnt + 16'd1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    range_word_t want;
    range_word_t got;
    if (!rst_ni) begin
      cfg        = epr_pkg::CFG_RESET;
      meas_phase = epr_pkg::PH_READY;
      presc_cnt  = 8'd0;
      usec_cnt   = 16'd0;
      filt_cnt   = 4'd0;
      stable_lvl = 1'b0;
      expected_words.delete();
      errors_o   = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (epr_pkg::cfg_idx_e'(cfg_index_i))
          epr_pkg::CFG_CLOCKS_PER_US: cfg.clocks_per_us = cfg_wdata_i[7:0];
          epr_pkg::CFG_FILTER_LENGTH: cfg.filter_length = cfg_wdata_i[3:0];
          epr_pkg::CFG_WAIT_LIMIT_US: cfg.wait_limit_us = cfg_wdata_i[15:0];
          epr_pkg::CFG_MAX_RANGE_CM:  cfg.max_range_cm  = cfg_wdata_i[10:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.range_cm = m_axis_tdata[15:0];
        got.pulse_us = m_axis_tdata[31:16];
        got.in_range = m_axis_tdata[32];
        got.failed   = m_axis_tuser;
        if (expected_words.size() == 0) begin
          errors_o = errors_o + 1;
          $display("%0t: unexpected range word: range=%0d pulse=%0d in_range=%0b failed=%0b",
                   $time, got.range_cm, got.pulse_us, got.in_range, got.failed);
        end else begin
          want      = expected_words.pop_front();
          pending_o = pending_o - 1;
          if (got.range_cm !== want.range_cm || got.pulse_us !== want.pulse_us ||
              got.in_range !== want.in_range || got.failed !== want.failed) begin
            errors_o = errors_o + 1;
            $display("%0t: range word mismatch: expected range=%0d pulse=%0d in_range=%0b failed=%0b",
                     $time, want.range_cm, want.pulse_us, want.in_range, want.failed);
            $display("%0t:                      actual   range=%0d pulse=%0d in_range=%0b failed=%0b",
                     $time, got.range_cm, got.pulse_us, got.in_range, got.failed);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (tick_model(s_axis_tdata[0], s_axis_tdata[1], want)) begin
          expected_words.push_back(want);
          pending_o = pending_o + 1;
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_WORDS  = 800;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata;   // arm, echo_level
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [39:0]                    m_axis_tdata;   // range_cm, pulse_us, in_range
  logic                           m_axis_tuser;   // failed
  logic                           cfg_we_i;
  logic [epr_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [epr_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  int unsigned errors;
  int unsigned pending;
  int unsigned src_idle;
  int unsigned sink_stall;
  int unsigned hold_seq;
  int unsigned words_sent;
  int unsigned cur_div;
  int unsigned cur_flen;
  logic        echo_lvl;

  echo_pulse_range_capture i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  echo_range_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever hold_seq moves.
  initial begin
    int unsigned seen;
    int unsigned left;
    seen          = 0;
    left          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != seen) begin
        seen = hold_seq;
        left = HOLD_CYCLES;
      end
      if (left != 0) begin
        left = left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  // Offer one sensor tick and hold it until accepted. Call and return at negedge.
  task automatic put_tick(input logic arm, input logic lvl);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, lvl, arm};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    echo_lvl   = lvl;
    words_sent = words_sent + 1;
    @(negedge clk_i);
  endtask

  task automatic hold_level(input logic lvl, input int unsigned n);
    repeat (n) put_tick(1'b0, lvl);
  endtask

  // Stop sending and wait for every outstanding range word.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] div, input logic [3:0] flen,
                            input logic [15:0] wlim, input logic [10:0] maxr);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= epr_pkg::CFG_CLOCKS_PER_US;
    cfg_wdata_i <= {8'd0, div};
    @(negedge clk_i);
    cfg_index_i <= epr_pkg::CFG_FILTER_LENGTH;
    cfg_wdata_i <= {12'd0, flen};
    @(negedge clk_i);
    cfg_index_i <= epr_pkg::CFG_WAIT_LIMIT_US;
    cfg_wdata_i <= wlim;
    @(negedge clk_i);
    cfg_index_i <= epr_pkg::CFG_MAX_RANGE_CM;
    cfg_wdata_i <= {5'd0, maxr};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_div  = (div == 8'd0) ? 1 : div;
    cur_flen = (flen == 4'd0) ? 1 : flen;
  endtask

  task automatic set_mode(input int unsigned mode);
    case (mode)
      0: begin src_idle = 0;  sink_stall = 0;  end
      1: begin src_idle = 65; sink_stall = 0;  end
      2: begin src_idle = 0;  sink_stall = 65; end
      default: begin src_idle = 19; sink_stall = 19; end
    endcase
  endtask

  task automatic pick_config();
    logic [7:0]  div;
    logic [3:0]  flen;
    logic [15:0] wlim;
    logic [10:0] maxr;
    case ($urandom_range(7))
      0: div = 8'd0;
      1: div = 8'd255;
      default: div = 8'($urandom_range(1, 3));
    endcase
    case ($urandom_range(7))
      0: flen = 4'd0;
      1: flen = 4'd15;
      2: flen = 4'd1;
      default: flen = 4'($urandom_range(2, 6));
    endcase
    case ($urandom_range(7))
      0: wlim = 16'd0;
      1: wlim = 16'hFFFF;
      2: wlim = 16'd1;
      default: wlim = 16'($urandom_range(2, 60));
    endcase
    case ($urandom_range(5))
      0: maxr = 11'd0;
      1: maxr = 11'd1130;
      default: maxr = 11'($urandom_range(0, 3));
    endcase
    write_regs(div, flen, wlim, maxr);
  endtask

  // Arm, optional glitch shorter than the filter, then one echo pulse.
  task automatic fire_shot();
    int unsigned width;
    logic        base;
    put_tick(1'b1, ($urandom_range(9) == 0) ? ~echo_lvl : echo_lvl);
    base = echo_lvl;
    hold_level(base, $urandom_range(0, 6));
    if (cur_flen > 1 && $urandom_range(4) == 0) begin
      hold_level(~base, $urandom_range(1, cur_flen - 1));
      hold_level(base, $urandom_range(1, 3));
    end
    case ($urandom_range(9))
      0: width = (cur_div <= 3) ? $urandom_range(58 * cur_div, 116 * cur_div)
                                : $urandom_range(1, 4 * cur_flen);
      1: width = $urandom_range(1, cur_flen);
      default: width = $urandom_range(cur_flen, cur_flen + 24);
    endcase
    hold_level(~base, width);
    hold_level(base, cur_flen + $urandom_range(0, 4));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 16)) put_tick($urandom_range(7) == 0, 1'($urandom_range(1)));
  endtask

  initial begin
    int unsigned start;
    int unsigned shots;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = epr_pkg::CFG_CLOCKS_PER_US;
    cfg_wdata_i   = '0;
    src_idle      = 0;
    sink_stall    = 0;
    hold_seq      = 0;
    words_sent    = 0;
    cur_div       = 48;
    cur_flen      = 8;
    echo_lvl      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: a pulse of a few microseconds, then an edge that must be ignored
    hold_level(1'b0, 20);
    hold_level(1'b1, 120);
    hold_level(1'b0, 20);
    hold_level(1'b1, 12);

    // zero divider and zero filter act as one; widths around one centimeter
    write_regs(8'd0, 4'd0, 16'hFFFF, 11'd0);
    put_tick(1'b1, ~echo_lvl);
    hold_level(echo_lvl, 4);
    hold_level(~echo_lvl, 58);
    hold_level(~echo_lvl, 2);
    put_tick(1'b1, echo_lvl);
    hold_level(~echo_lvl, 60);
    hold_level(~echo_lvl, 2);

    // zero wait limit times out on the first microsecond
    write_regs(8'd1, 4'd1, 16'd0, 11'd1130);
    put_tick(1'b1, echo_lvl);
    hold_level(echo_lvl, 3);
    hold_level(~echo_lvl, 3);

    // re-arm in the middle of a pulse
    write_regs(8'd2, 4'd2, 16'd100, 11'd5);
    put_tick(1'b1, echo_lvl);
    hold_level(~echo_lvl, 10);
    put_tick(1'b1, echo_lvl);
    hold_level(echo_lvl, 6);
    hold_level(~echo_lvl, 10);
    hold_level(~echo_lvl, 10);

    // slowest divider and longest filter
    write_regs(8'd255, 4'd15, 16'd1, 11'd1130);
    put_tick(1'b1, echo_lvl);
    hold_level(~echo_lvl, 300);
    hold_level(~echo_lvl, 20);
    put_tick(1'b1, echo_lvl);
    hold_level(echo_lvl, 270);

    // back-to-back timeouts while the result side holds off
    write_regs(8'd1, 4'd1, 16'd1, 11'd3);
    hold_seq = hold_seq + 1;
    repeat (30) begin
      put_tick(1'b1, echo_lvl);
      put_tick(1'b0, echo_lvl);
    end

    start = words_sent;
    shots = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      if (shots % 4 == 0) begin
        pick_config();
        set_mode((shots / 4) % 4);
      end
      if ($urandom_range(4) == 0) begin
        noise_burst();
      end else begin
        fire_shot();
      end
      shots = shots + 1;
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
